FILE: src/orbm_pkg.sv
// Shared constants, opcodes and types of the one-bit register machine.
`default_nettype none
package orbm_pkg;

    localparam int PROGRAM_WORDS = 65536;
    localparam int REGISTER_BITS = 128;
    localparam int PROG_AW       = $clog2(PROGRAM_WORDS);
    localparam int WORD_W        = 16;
    localparam int IDX_W         = $clog2(REGISTER_BITS);

    localparam int IN_BIT  = 16;
    localparam int IN_ACK  = 17;
    localparam int OUT_BIT = 18;
    localparam int OUT_REQ = 19;

    localparam logic [1:0] OP_COPY = 2'd0;
    localparam logic [1:0] OP_LOAD = 2'd1;
    localparam logic [1:0] OP_NAND = 2'd2;
    localparam logic [1:0] OP_XOR  = 2'd3;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_EXEC  = 1'b1;

    typedef struct packed {
        logic [REGISTER_BITS-1:0] bits;
        logic                     out_valid;
        logic                     out_bit;
        logic                     input_taken;
        logic                     halt;
    } t_exec_res;

endpackage
`default_nettype wire

FILE: src/orbm_ram.sv
// Generic single-port synchronous RAM with registered read data.
`default_nettype none
module orbm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
`default_nettype wire

FILE: src/orbm_exec.sv
// Instruction execute step: counter advance, bit update, halt test and handshakes.
`default_nettype none
module orbm_exec import orbm_pkg::*; (
    input  wire logic [REGISTER_BITS-1:0] i_bits,
    input  wire logic [WORD_W-1:0]        i_inst,
    input  wire logic [WORD_W-1:0]        i_load_word,
    input  wire logic                     i_in_bit,
    output t_exec_res                     o_res
);

    localparam int EXT_W = REGISTER_BITS + WORD_W;

    logic [1:0]               op;
    logic [IDX_W-1:0]         src;
    logic [IDX_W-1:0]         dst;
    logic [WORD_W-1:0]        pc_inc;
    logic [REGISTER_BITS-1:0] bits_pc;
    logic [REGISTER_BITS-1:0] bits_op;
    logic [REGISTER_BITS-1:0] bits_hs;
    logic [EXT_W-1:0]         ext;
    logic [EXT_W-1:0]         wmask;
    logic [EXT_W-1:0]         wdata;
    logic [WORD_W-1:0]        src_word;
    logic [WORD_W-1:0]        put_word;
    logic                     halt;
    logic                     out_valid;
    logic                     out_bit;
    logic                     taken;

    always_comb begin
        op       = i_inst[1:0];
        src      = i_inst[15:9];
        dst      = i_inst[8:2];
        pc_inc   = i_bits[WORD_W-1:0] + WORD_W'(1);
        bits_pc  = {i_bits[REGISTER_BITS-1:WORD_W], pc_inc};
        ext      = {{WORD_W{1'b0}}, bits_pc};
        src_word = WORD_W'(ext >> src);
        put_word = (op == OP_LOAD) ? i_load_word : src_word;
        wmask    = EXT_W'({WORD_W{1'b1}}) << dst;
        wdata    = EXT_W'(put_word) << dst;
        bits_op  = bits_pc;
        unique case (op)
            OP_COPY, OP_LOAD: begin
                bits_op = (bits_pc & ~wmask[REGISTER_BITS-1:0])
                        | (wdata[REGISTER_BITS-1:0] & wmask[REGISTER_BITS-1:0]);
            end
            OP_NAND: begin
                bits_op[dst] = ~(bits_pc[src] & bits_pc[dst]);
            end
            OP_XOR: begin
                bits_op[dst] = bits_pc[src] ^ bits_pc[dst];
            end
            default: begin
                bits_op = bits_pc;
            end
        endcase

        halt      = (bits_op[WORD_W-1:0] == i_bits[WORD_W-1:0]);
        bits_hs   = bits_op;
        out_valid = 1'b0;
        out_bit   = 1'b0;
        taken     = 1'b0;
        if (!halt) begin
            if (bits_op[OUT_REQ]) begin
                out_valid        = 1'b1;
                out_bit          = bits_op[OUT_BIT];
                bits_hs[OUT_REQ] = 1'b0;
            end
            if (!bits_op[IN_ACK]) begin
                taken           = 1'b1;
                bits_hs[IN_BIT] = i_in_bit;
                bits_hs[IN_ACK] = 1'b1;
            end
        end

        o_res.bits        = bits_hs;
        o_res.out_valid   = out_valid;
        o_res.out_bit     = out_bit;
        o_res.input_taken = taken;
        o_res.halt        = halt;
    end

endmodule
`default_nettype wire

FILE: src/one_bit_register_machine_core_unit.sv
// Top level of the one-bit register machine: sequencer, bit state and program memory.
//
// Input stream: s_axis_tuser selects the operation (0 stores one program word,
// 1 executes one instruction); s_axis_tdata carries prog_addr, prog_word and in_bit.
// Output stream: one transfer per input transfer, in order, with out_valid,
// out_bit, input_taken and halted in m_axis_tdata.
// Configuration: i_cfg_we writes first_input_bit; before the first executed
// instruction it also sets register bit 16.
// Sequencing: a program write or a step while halted is answered straight from idle;
// an instruction reads program memory at the counter, then updates the 128 register
// bits, and a load adds a second read of the memory port for the loaded word. A new
// instruction is taken only once the last one is finished, as the single port of the
// program memory and the counter that each fetch depends on require; program writes
// and halted steps are taken one per cycle while the output is not stalled.
// Reset (synchronous, active low) clears all bits but bit 17, clears the halt
// flag and first_input_bit; program memory is undefined until written.
// While m_axis_tready is low a finished result holds in the output register and
// s_axis_tready stays low while that result waits.
`default_nettype none
module one_bit_register_machine_core_unit import orbm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // prog_addr[15:0], prog_word[31:16], in_bit[32]
    input  wire logic        s_axis_tuser,  // func[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [7:0]  m_axis_tdata,  // out_valid[0], out_bit[1], input_taken[2], halted[3]
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0]               r_state;
    logic [1:0]               n_state;
    logic [REGISTER_BITS-1:0] r_bits;
    logic [REGISTER_BITS-1:0] n_bits;
    logic                     r_stopped;
    logic                     n_stopped;
    logic                     r_started;
    logic                     n_started;
    logic                     r_first;
    logic                     n_first;
    logic                     r_in_bit;
    logic                     n_in_bit;
    logic                     r_oob;
    logic                     n_oob;
    logic [WORD_W-1:0]        r_inst;
    logic [WORD_W-1:0]        n_inst;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic [3:0]               r_out_data;
    logic [3:0]               n_out_data;

    logic                     in_xfer;
    logic                     func;
    logic [WORD_W-1:0]        prog_addr;
    logic [WORD_W-1:0]        prog_word;
    logic                     in_bit;
    logic [WORD_W-1:0]        pc;
    logic                     pc_oob;
    logic                     addr_ok;
    logic                     ram_we;
    logic [PROG_AW-1:0]       ram_addr;
    logic [WORD_W-1:0]        ram_rdata;
    logic [WORD_W-1:0]        mem_word;
    logic [WORD_W-1:0]        exec_inst;
    logic [WORD_W-1:0]        load_word;
    t_exec_res                res;

    assign func      = s_axis_tuser;
    assign prog_addr = s_axis_tdata[15:0];
    assign prog_word = s_axis_tdata[31:16];
    assign in_bit    = s_axis_tdata[32];
    assign pc        = r_bits[WORD_W-1:0];
    assign pc_oob    = ({1'b0, pc} >= 17'(PROGRAM_WORDS));
    assign addr_ok   = ({1'b0, prog_addr} < 17'(PROGRAM_WORDS));

    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_data};

    assign mem_word  = r_oob ? '0 : ram_rdata;
    assign exec_inst = (r_state == S_LOAD) ? r_inst : mem_word;
    assign load_word = ram_rdata;

    always_comb begin
        ram_we   = 1'b0;
        ram_addr = PROG_AW'(pc);
        if (r_state == S_EXEC) begin
            ram_addr = PROG_AW'(mem_word[15:9]);
        end else if (in_xfer && func == FUNC_WRITE) begin
            ram_we   = addr_ok;
            ram_addr = PROG_AW'(prog_addr);
        end
    end

    orbm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PROGRAM_WORDS)
    ) u_prog_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (prog_word),
        .o_rdata (ram_rdata)
    );

    orbm_exec u_exec (
        .i_bits      (r_bits),
        .i_inst      (exec_inst),
        .i_load_word (load_word),
        .i_in_bit    (r_in_bit),
        .o_res       (res)
    );

    always_comb begin
        n_state     = r_state;
        n_bits      = r_bits;
        n_stopped   = r_stopped;
        n_started   = r_started;
        n_first     = r_first;
        n_in_bit    = r_in_bit;
        n_oob       = r_oob;
        n_inst      = r_inst;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;

        if (i_cfg_we) begin
            n_first = i_cfg_wdata;
            if (!r_started) begin
                n_bits[IN_BIT] = i_cfg_wdata;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (func == FUNC_WRITE || r_stopped) begin
                        n_out_valid = 1'b1;
                        n_out_data  = {r_stopped, 3'b0};
                    end else begin
                        n_started = 1'b1;
                        n_in_bit  = in_bit;
                        n_oob     = pc_oob;
                        n_state   = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                n_inst = mem_word;
                n_oob  = 1'b0;
                if (mem_word[1:0] == OP_LOAD) begin
                    n_state = S_LOAD;
                end else begin
                    n_bits      = res.bits;
                    n_stopped   = res.halt;
                    n_out_valid = 1'b1;
                    n_out_data  = {res.halt, res.input_taken, res.out_bit, res.out_valid};
                    n_state     = S_IDLE;
                end
            end
            S_LOAD: begin
                n_bits      = res.bits;
                n_stopped   = res.halt;
                n_out_valid = 1'b1;
                n_out_data  = {res.halt, res.input_taken, res.out_bit, res.out_valid};
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bits      <= REGISTER_BITS'(1) << IN_ACK;
            r_stopped   <= 1'b0;
            r_started   <= 1'b0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
            r_oob       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bits      <= n_bits;
            r_stopped   <= n_stopped;
            r_started   <= n_started;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
            r_oob       <= n_oob;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_bit   <= n_in_bit;
        r_inst     <= n_inst;
        r_out_data <= n_out_data;
    end

endmodule
`default_nettype wire

FILE: src/orbm_chk.sv
// Port-level checker for the one-bit register machine, bound to the top level.
`default_nettype none
module orbm_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transfer dropped or changed while stalled");

    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while a stalled result occupies the output");

    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser
        |=> m_axis_tvalid && m_axis_tdata[2:0] == 3'b000)
        else $error("program write did not give a quiet result next cycle");

    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[0] && !m_axis_tdata[2])
        else $error("halted result also reports a handshake");

endmodule

bind one_bit_register_machine_core_unit orbm_chk u_orbm_chk (.*);
`default_nettype wire
